// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define LVQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lvq assertion failed");

// Implication form, same reset handling.
`define LVQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  `LVQ_ASSERT(lbl, clk, rstn, (ante) |-> (cons))

`endif

// ----- sv/lvq_pkg.sv -----
// Package: sizes, command and status codes, compare result type.
package lvq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PAGE_BITS   = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int PAGE_ID_W   = 16;
  localparam int OCC_W       = 5;
  localparam int IN_DATA_W   = 24;  // page_id + page_locked, byte padded
  localparam int OUT_DATA_W  = 24;  // victim_page + occupancy, byte padded

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_LOCK   = 2'd2,
    CMD_UNLOCK = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2
  } status_e;

  typedef struct packed {
    logic in_range;  // read position lies below the entry count
    logic page_eq;   // entry page equals the search key
    logic free;      // entry is not pinned
  } lvq_cmp_t;

endpackage

// ----- sv/lvq_cmp_unit.sv -----
// Shared compare unit used by every scan and shift step.
module lvq_cmp_unit
  import lvq_pkg::*;
(
  input  logic [CNT_W-1:0]     rd_ptr_i,
  input  logic [CNT_W-1:0]     count_i,
  input  logic [PAGE_BITS-1:0] rd_page_i,
  input  logic                 rd_pin_i,
  input  logic [PAGE_BITS-1:0] key_i,
  output lvq_cmp_t             cmp_o
);

  always_comb begin
    cmp_o.in_range = (rd_ptr_i < count_i);
    cmp_o.page_eq  = (rd_page_i == key_i);
    cmp_o.free     = ~rd_pin_i;
  end

endmodule

// ----- sv/lru_victim_queue_with_pinning_unit.sv -----
// Top level: LRU victim queue with pinned pages, one-entry-per-cycle sequencer.
//
//   channel  | dir | tdata (low bit up)                  | tuser
//   ---------+-----+-------------------------------------+------------
//   s_axis   | in  | page_id[15:0], page_locked[16]      | cmd[1:0]
//   m_axis   | out | victim_page[15:0], occupancy[20:16] | status[1:0]
//
// Steps per item: push goes straight to FINISH, lock/unlock scan every entry, pop
// scans to the first unpinned entry, then closes the gap one entry per cycle. The
// single read port of the entry registers and the shared compare unit set that pace.
// Reset clears count, pin marks and the handshake state; page storage is not
// cleared. An input item is taken only in IDLE; a finished result waits in the
// output register, and the sequencer holds in FINISH while it is stalled.
module lru_victim_queue_with_pinning_unit
  import lvq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // page_id[15:0], page_locked[16]
  input  logic [1:0]            s_axis_tuser,   // cmd[1:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // victim_page[15:0], occupancy[20:16]
  output logic [1:0]            m_axis_tuser    // status[1:0]
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,   // walk entries oldest first
    ST_SHIFT,  // close the gap left by the victim
    ST_FINISH  // hand result to the output register
  } state_e;

  state_e                 state_q;
  cmd_e                   cmd_q;
  logic [PAGE_BITS-1:0]   key_q;
  logic [CNT_W-1:0]       ptr_q;
  logic [CNT_W-1:0]       count_q;
  logic [QUEUE_DEPTH-1:0] pin_q;
  logic [PAGE_BITS-1:0]   entry_page_q [QUEUE_DEPTH];
  logic [PAGE_BITS-1:0]   victim_q;
  status_e                status_q;

  logic                   out_valid_q;
  logic [PAGE_ID_W-1:0]   out_victim_q;
  logic [OCC_W-1:0]       out_occ_q;
  status_e                out_status_q;

  logic                   in_acc;
  cmd_e                   in_cmd;
  logic [PAGE_BITS-1:0]   in_page;
  logic                   in_mark;

  logic [CNT_W-1:0]       rd_ptr;
  logic [PAGE_BITS-1:0]   rd_page;
  logic                   rd_pin;
  lvq_cmp_t               cmp;

  logic                   wr_en;
  logic [IDX_W-1:0]       wr_idx;
  logic [PAGE_BITS-1:0]   wr_data;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign in_cmd        = cmd_e'(s_axis_tuser);
  assign in_page       = s_axis_tdata[PAGE_BITS-1:0];
  assign in_mark       = s_axis_tdata[PAGE_ID_W];

  // One read port: current entry while scanning, the next one while shifting.
  assign rd_ptr  = (state_q == ST_SHIFT) ? ptr_q + CNT_W'(1) : ptr_q;
  assign rd_page = entry_page_q[rd_ptr[IDX_W-1:0]];
  assign rd_pin  = pin_q[rd_ptr[IDX_W-1:0]];

  lvq_cmp_unit u_cmp (
    .rd_ptr_i  (rd_ptr),
    .count_i   (count_q),
    .rd_page_i (rd_page),
    .rd_pin_i  (rd_pin),
    .key_i     (key_q),
    .cmp_o     (cmp)
  );

  // Page storage write port: push appends, shift moves an entry down by one.
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = count_q[IDX_W-1:0];
    wr_data = in_page;
    if (in_acc && (in_cmd == CMD_PUSH) && (count_q < CNT_W'(QUEUE_DEPTH))) begin
      wr_en = 1'b1;
    end else if ((state_q == ST_SHIFT) && cmp.in_range) begin
      wr_en   = 1'b1;
      wr_idx  = ptr_q[IDX_W-1:0];
      wr_data = rd_page;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_page_q[wr_idx] <= wr_data;
    end
  end

  // Sequencer, pin marks, count and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cmd_q        <= CMD_PUSH;
      key_q        <= '0;
      ptr_q        <= '0;
      count_q      <= '0;
      pin_q        <= '0;
      victim_q     <= '0;
      status_q     <= STAT_DONE;
      out_valid_q  <= 1'b0;
      out_victim_q <= '0;
      out_occ_q    <= '0;
      out_status_q <= STAT_DONE;
    end else begin
      // FINISH reloads the register itself when the old result leaves
      if (out_valid_q && m_axis_tready && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            cmd_q    <= in_cmd;
            key_q    <= in_page;
            ptr_q    <= '0;
            victim_q <= '0;
            status_q <= STAT_DONE;
            if (in_cmd == CMD_PUSH) begin
              if (count_q >= CNT_W'(QUEUE_DEPTH)) begin
                status_q <= STAT_FULL;
              end else begin
                pin_q[count_q[IDX_W-1:0]] <= in_mark;
                count_q <= count_q + CNT_W'(1);
              end
              state_q <= ST_FINISH;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (!cmp.in_range) begin
            status_q <= (cmd_q == CMD_POP) ? STAT_NONE : STAT_DONE;
            state_q  <= ST_FINISH;
          end else begin
            case (cmd_q)
              CMD_POP: begin
                if (cmp.free) begin
                  victim_q <= rd_page;
                  state_q  <= ST_SHIFT;
                end else begin
                  ptr_q <= ptr_q + CNT_W'(1);
                end
              end
              CMD_LOCK: begin
                if (cmp.page_eq) begin
                  pin_q[ptr_q[IDX_W-1:0]] <= 1'b1;
                end
                ptr_q <= ptr_q + CNT_W'(1);
              end
              CMD_UNLOCK: begin
                if (cmp.page_eq) begin
                  pin_q[ptr_q[IDX_W-1:0]] <= 1'b0;
                end
                ptr_q <= ptr_q + CNT_W'(1);
              end
              default: begin
                ptr_q <= ptr_q + CNT_W'(1);
              end
            endcase
          end
        end
        ST_SHIFT: begin
          if (cmp.in_range) begin
            pin_q[ptr_q[IDX_W-1:0]] <= rd_pin;
            ptr_q <= ptr_q + CNT_W'(1);
          end else begin
            // ptr now sits on the last entry, which becomes free
            pin_q[ptr_q[IDX_W-1:0]] <= 1'b0;
            count_q <= count_q - CNT_W'(1);
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q  <= 1'b1;
            out_victim_q <= PAGE_ID_W'(victim_q);
            out_occ_q    <= OCC_W'(count_q);
            out_status_q <= status_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - PAGE_ID_W - OCC_W)'(0), out_occ_q, out_victim_q};
  assign m_axis_tuser  = out_status_q;

endmodule

// ----- sv/lvq_checker.sv -----
// Port-level checker for the victim queue, bound to the top level.
`include "assert_macros.svh"

module lvq_checker
  import lvq_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]            m_axis_tuser
);

  logic                  in_acc;
  logic                  out_stall;
  logic [OUT_DATA_W+1:0] out_word;
  logic                  status_ok;
  logic                  status_done;
  logic [OCC_W-1:0]      out_occ;
  logic [PAGE_ID_W-1:0]  out_victim;

  assign in_acc      = s_axis_tvalid & s_axis_tready;
  assign out_stall   = m_axis_tvalid & ~m_axis_tready;
  assign out_word    = {m_axis_tuser, m_axis_tdata};
  assign status_done = (m_axis_tuser == STAT_DONE);
  assign status_ok   = status_done || (m_axis_tuser == STAT_FULL) ||
                       (m_axis_tuser == STAT_NONE);
  assign out_occ     = m_axis_tdata[PAGE_ID_W +: OCC_W];
  assign out_victim  = m_axis_tdata[PAGE_ID_W-1:0];

  // stalled result holds
  `LVQ_ASSERT_IMP(a_out_hold, clk_i, rst_ni, out_stall, ##1 (m_axis_tvalid && $stable(out_word)))
  // one command at a time: no accept right after an accept
  `LVQ_ASSERT_IMP(a_busy_after_acc, clk_i, rst_ni, in_acc, ##1 !s_axis_tready)
  // status code is one of done, full, none
  `LVQ_ASSERT_IMP(a_status_code, clk_i, rst_ni, m_axis_tvalid, status_ok)
  // occupancy never above the queue depth
  `LVQ_ASSERT_IMP(a_occ_bound, clk_i, rst_ni, m_axis_tvalid, out_occ <= OCC_W'(QUEUE_DEPTH))
  // no victim page unless the command completed normally
  `LVQ_ASSERT_IMP(a_victim_zero, clk_i, rst_ni, m_axis_tvalid && !status_done, out_victim == '0)

endmodule

bind lru_victim_queue_with_pinning_unit lvq_checker u_lvq_checker (.*);
